// ===== hw/rtl/amcl_pkg.sv =====
// Shared types, constants and codes for the alpha matte Charbonnier loss unit.
// No dependencies; imported by every module of the block except amcl_checker.
package amcl_pkg;

   localparam int unsigned MAX_PIXELS_DEFAULT = 1048576;

   // Fixed-point formats
   localparam int FRAC_BITS  = 12;
   localparam int WIDE_SHIFT = 24 - FRAC_BITS;
   localparam int MASK_W     = FRAC_BITS + 1;         // mask value 0..2^F
   localparam int DIFF_W     = 18;                    // signed QF difference
   localparam int MAG_W      = DIFF_W - 1 + WIDE_SHIFT;
   localparam int ROOT_W     = 29;
   localparam int SUM_W      = 36;
   localparam int KEPT_W     = 21;
   localparam int BATCH_W    = 40;
   localparam int LOSS_W     = 16;
   localparam int GRAD_W     = 32;
   localparam int PIXEL_COUNT_W = 21;

   // Reciprocal of 255 scaled by 2^36, rounded up
   localparam int RECIP_SHIFT = 36;
   localparam longint unsigned RECIP_255 = ((64'd1 << RECIP_SHIFT) + 64'd254) / 64'd255;
   localparam int RECIP_W = 29;

   // Shared unit
   localparam int UNIT_W       = 64;
   localparam int STEPS_W      = 7;
   localparam int SQRT_STEPS   = 29;
   localparam int GRAD_DIV_STEPS = 59;
   localparam int LOSS_DIV_STEPS = 37;
   localparam logic [UNIT_W-1:0] SQRT_TOP_BIT = 64'd1 << 56;

   localparam logic [PIXEL_COUNT_W-1:0] PIXEL_COUNT_INIT = 21'd65536;

   // APB register map
   localparam int ADDR_W = 4;
   typedef enum logic [1:0] {
      REG_USE_TRIMAP  = 2'd0,
      REG_KEEP_LABEL  = 2'd1,
      REG_EPSILON_SQ  = 2'd2,
      REG_PIXEL_COUNT = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic                     use_trimap;
      logic [7:0]               keep_label;
      logic [31:0]              epsilon_square;
      logic [PIXEL_COUNT_W-1:0] pixel_count;
   } cfg_type;

   typedef enum logic {
      OP_SQRT = 1'b0,
      OP_DIV  = 1'b1
   } unit_op_type;

   typedef struct packed {
      logic               start;
      unit_op_type        op;
      logic [UNIT_W-1:0]  opa;
      logic [UNIT_W-1:0]  opb;
      logic [STEPS_W-1:0] steps;
   } unit_req_type;

   typedef struct packed {
      logic              done;
      logic [UNIT_W-1:0] result;
   } unit_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIFF,
      ST_SQ,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_DEN,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SIDE_END,
      ST_ACC,
      ST_LOSS_GO,
      ST_LOSS_WAIT,
      ST_CLOSE,
      ST_OUT
   } seq_state_type;

endpackage

// ===== hw/rtl/amcl_csr.sv =====
// APB-style configuration registers of the loss unit.
// Depends on amcl_pkg.
module amcl_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [amcl_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output amcl_pkg::cfg_type           cfg
);
   import amcl_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.use_trimap     <= 1'b0;
         cfg_ff.keep_label     <= 8'd0;
         cfg_ff.epsilon_square <= 32'd0;
         cfg_ff.pixel_count    <= PIXEL_COUNT_INIT;
      end else if (wr_en) begin
         unique case (index)
            REG_USE_TRIMAP:  cfg_ff.use_trimap     <= pwdata[0];
            REG_KEEP_LABEL:  cfg_ff.keep_label     <= pwdata[7:0];
            REG_EPSILON_SQ:  cfg_ff.epsilon_square <= pwdata;
            REG_PIXEL_COUNT: cfg_ff.pixel_count    <= pwdata[PIXEL_COUNT_W-1:0];
            default:         cfg_ff.use_trimap     <= cfg_ff.use_trimap;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_USE_TRIMAP:  prdata = {31'd0, cfg_ff.use_trimap};
         REG_KEEP_LABEL:  prdata = {24'd0, cfg_ff.keep_label};
         REG_EPSILON_SQ:  prdata = cfg_ff.epsilon_square;
         REG_PIXEL_COUNT: prdata = {11'd0, cfg_ff.pixel_count};
         default:         prdata = 32'd0;
      endcase
   end

endmodule

// ===== hw/rtl/amcl_iter_unit.sv =====
// Shared iterative unit: bit-pair square root or restoring division,
// one step per cycle. Depends on amcl_pkg.
module amcl_iter_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  amcl_pkg::unit_req_type req,
   output amcl_pkg::unit_rsp_type rsp
);
   import amcl_pkg::*;

   logic               busy_ff, done_ff;
   logic [STEPS_W-1:0] cnt_ff;
   unit_op_type        op_ff;
   logic [UNIT_W-1:0]  rem_ff, rem_in;
   logic [UNIT_W-1:0]  acc_ff, acc_in;
   logic [UNIT_W-1:0]  bit_ff;
   logic [UNIT_W-1:0]  dvs_ff;
   logic [UNIT_W-1:0]  trial;
   logic [UNIT_W-1:0]  shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == STEPS_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         op_ff  <= req.op;
         cnt_ff <= req.steps;
         dvs_ff <= req.opb;
         bit_ff <= SQRT_TOP_BIT;
         if (req.op == OP_SQRT) begin
            rem_ff <= req.opa;
            acc_ff <= '0;
         end else begin
            rem_ff <= '0;
            acc_ff <= req.opa;
         end
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - STEPS_W'(1);
         rem_ff <= rem_in;
         acc_ff <= acc_in;
         bit_ff <= bit_ff >> 2;
      end
   end

   always_comb begin
      trial   = acc_ff + bit_ff;
      shifted = {rem_ff[UNIT_W-2:0], acc_ff[UNIT_W-1]};
      unique case (op_ff)
         OP_SQRT: begin
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               acc_in = (acc_ff >> 1) + bit_ff;
            end else begin
               rem_in = rem_ff;
               acc_in = acc_ff >> 1;
            end
         end
         OP_DIV: begin
            if (shifted >= dvs_ff) begin
               rem_in = shifted - dvs_ff;
               acc_in = {acc_ff[UNIT_W-2:0], 1'b1};
            end else begin
               rem_in = shifted;
               acc_in = {acc_ff[UNIT_W-2:0], 1'b0};
            end
         end
         default: begin
            rem_in = rem_ff;
            acc_in = acc_ff;
         end
      endcase
   end

   assign rsp.done   = done_ff;
   assign rsp.result = acc_ff;

endmodule

// ===== hw/rtl/amcl_seq.sv =====
// Per-pixel sequencer: operand prep, gradient and loss bookkeeping, result register.
// Drives the shared unit in amcl_iter_unit. Depends on amcl_pkg.
module amcl_seq #(
   parameter int unsigned MAX_IMAGE_PIXELS = amcl_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  amcl_pkg::cfg_type             cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [15:0]            req_pred_fg,
   input  logic signed [15:0]            req_pred_bg,
   input  logic [7:0]                    req_mask_byte,
   input  logic [7:0]                    req_trimap_value,
   input  logic                          req_last_in_image,
   input  logic                          req_last_in_batch,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_grad_fg,
   output logic signed [31:0]            rsp_grad_bg,
   output logic [15:0]                   rsp_image_loss,
   output logic                          rsp_image_done,
   output logic                          rsp_image_empty,
   output logic [39:0]                   rsp_batch_loss,
   output logic                          rsp_batch_done,
   output amcl_pkg::unit_req_type        unit_req,
   input  amcl_pkg::unit_rsp_type        unit_rsp
);
   import amcl_pkg::*;

   localparam int NORM_W = $clog2(MAX_IMAGE_PIXELS + 1);
   localparam int CMP_W  = (NORM_W > PIXEL_COUNT_W) ? NORM_W : PIXEL_COUNT_W;
   localparam int CNT_W  = (NORM_W > KEPT_W) ? NORM_W : KEPT_W;
   localparam int DEN_W  = ROOT_W + NORM_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_IMAGE_PIXELS);
   localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
   localparam logic [KEPT_W-1:0]  KEPT_MAX  = '1;
   localparam logic [BATCH_W-1:0] BATCH_MAX = '1;

   seq_state_type state_ff, state_in;

   logic signed [15:0]  fg_ff, bg_ff;
   logic [7:0]          mb_ff, tv_ff;
   logic                last_img_ff, last_batch_ff;
   logic [NORM_W-1:0]   norm_ff;
   logic [MASK_W-1:0]   m_ff;
   logic [MAG_W-1:0]    mag_fg_ff, mag_bg_ff;
   logic                neg_fg_ff, neg_bg_ff;
   logic                side_ff;
   logic [UNIT_W-1:0]   s_ff;
   logic [ROOT_W-1:0]   root_ff, root_fg_ff;
   logic [DEN_W-1:0]    den_ff;
   logic [GRAD_W-1:0]   gfg_ff, gbg_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [KEPT_W-1:0]   kept_ff;
   logic [BATCH_W-1:0]  batch_ff;
   logic [LOSS_W-1:0]   loss_ff;
   logic                empty_ff;

   logic signed [31:0]  rsp_grad_fg_ff, rsp_grad_bg_ff;
   logic [LOSS_W-1:0]   rsp_image_loss_ff;
   logic                rsp_image_done_ff, rsp_image_empty_ff;
   logic [BATCH_W-1:0]  rsp_batch_loss_ff;
   logic                rsp_batch_done_ff;

   // combinational datapath
   logic [CMP_W-1:0]            pc_ext;
   logic [NORM_W-1:0]           norm_calc;
   logic [19:0]                 mask_num;
   logic [48:0]                 mask_prod;
   logic [MASK_W-1:0]           one_minus_m;
   logic signed [DIFF_W-1:0]    d_fg, d_bg;
   logic [DIFF_W-2:0]           abs_fg, abs_bg;
   logic [MAG_W-1:0]            mag_cur;
   logic [2*MAG_W-1:0]          sq;
   logic [UNIT_W-1:0]           grad_num;
   logic [CNT_W-1:0]            loss_n;
   logic [UNIT_W-1:0]           loss_num;
   logic                        kept;
   logic [ROOT_W:0]             pl_round;
   logic [SUM_W:0]              sum_add;
   logic [BATCH_W:0]            batch_add;
   logic [GRAD_W-1:0]           quot;

   always_comb begin
      pc_ext = CMP_W'(cfg.pixel_count);
      if (pc_ext == '0) begin
         norm_calc = NORM_W'(1);
      end else if (pc_ext > MAX_CMP) begin
         norm_calc = NORM_W'(MAX_IMAGE_PIXELS);
      end else begin
         norm_calc = NORM_W'(pc_ext);
      end
   end

   // mask = round(byte * 2^F / 255) through a reciprocal multiply
   assign mask_num    = {mb_ff, {FRAC_BITS{1'b0}}} + 20'd127;
   assign mask_prod   = mask_num * RECIP_W'(RECIP_255);
   assign one_minus_m = MASK_W'(1 << FRAC_BITS) - m_ff;

   assign d_fg   = DIFF_W'(fg_ff) - $signed({{(DIFF_W-MASK_W){1'b0}}, m_ff});
   assign d_bg   = DIFF_W'(bg_ff) - $signed({{(DIFF_W-MASK_W){1'b0}}, one_minus_m});
   assign abs_fg = d_fg[DIFF_W-1] ? (DIFF_W-1)'(-d_fg) : d_fg[DIFF_W-2:0];
   assign abs_bg = d_bg[DIFF_W-1] ? (DIFF_W-1)'(-d_bg) : d_bg[DIFF_W-2:0];

   assign mag_cur = side_ff ? mag_bg_ff : mag_fg_ff;
   assign sq      = mag_cur * mag_cur;

   assign grad_num = (UNIT_W'(mag_cur) << 30) + UNIT_W'(den_ff >> 1);
   assign loss_n   = cfg.use_trimap ? CNT_W'(kept_ff) : CNT_W'(norm_ff);
   assign loss_num = UNIT_W'(sum_ff) + UNIT_W'(loss_n >> 1);

   assign kept      = !cfg.use_trimap || (tv_ff == cfg.keep_label);
   assign pl_round  = (ROOT_W+1)'(root_fg_ff) + (ROOT_W+1)'(1 << (WIDE_SHIFT-1));
   assign sum_add   = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(pl_round >> WIDE_SHIFT);
   assign batch_add = (BATCH_W+1)'(batch_ff) + (BATCH_W+1)'(loss_ff);
   assign quot      = unit_rsp.result[GRAD_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_PREP;
         ST_PREP:      state_in = ST_DIFF;
         ST_DIFF:      state_in = ST_SQ;
         ST_SQ:        state_in = ST_SQRT_GO;
         ST_SQRT_GO:   state_in = ST_SQRT_WAIT;
         ST_SQRT_WAIT: if (unit_rsp.done) state_in = ST_DEN;
         ST_DEN:       state_in = (root_ff == '0) ? ST_SIDE_END : ST_DIV_GO;
         ST_DIV_GO:    state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:  if (unit_rsp.done) state_in = ST_SIDE_END;
         ST_SIDE_END:  state_in = side_ff ? ST_ACC : ST_SQ;
         ST_ACC:       state_in = last_img_ff ? ST_LOSS_GO : ST_OUT;
         ST_LOSS_GO:   state_in = (kept_ff == '0) ? ST_CLOSE : ST_LOSS_WAIT;
         ST_LOSS_WAIT: if (unit_rsp.done) state_in = ST_CLOSE;
         ST_CLOSE:     state_in = ST_OUT;
         ST_OUT:       if (rsp_ready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      rsp_valid      = (state_ff == ST_OUT);
      unit_req.start = 1'b0;
      unit_req.op    = OP_SQRT;
      unit_req.opa   = s_ff;
      unit_req.opb   = '0;
      unit_req.steps = STEPS_W'(SQRT_STEPS);
      unique case (state_ff)
         ST_SQRT_GO: begin
            unit_req.start = 1'b1;
         end
         ST_DIV_GO: begin
            unit_req.start = 1'b1;
            unit_req.op    = OP_DIV;
            unit_req.opa   = grad_num << (UNIT_W - GRAD_DIV_STEPS);
            unit_req.opb   = UNIT_W'(den_ff);
            unit_req.steps = STEPS_W'(GRAD_DIV_STEPS);
         end
         ST_LOSS_GO: begin
            unit_req.start = (kept_ff != '0);
            unit_req.op    = OP_DIV;
            unit_req.opa   = loss_num << (UNIT_W - LOSS_DIV_STEPS);
            unit_req.opb   = UNIT_W'(loss_n);
            unit_req.steps = STEPS_W'(LOSS_DIV_STEPS);
         end
         default: unit_req.start = 1'b0;
      endcase
   end

   // control and running state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sum_ff   <= '0;
         kept_ff  <= '0;
         batch_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_ACC && kept) begin
            sum_ff  <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
            if (kept_ff != KEPT_MAX) kept_ff <= kept_ff + KEPT_W'(1);
         end
         if (state_ff == ST_CLOSE) begin
            sum_ff  <= '0;
            kept_ff <= '0;
            if (last_batch_ff) begin
               batch_ff <= '0;
            end else begin
               batch_ff <= batch_add[BATCH_W] ? BATCH_MAX : batch_add[BATCH_W-1:0];
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               fg_ff         <= req_pred_fg;
               bg_ff         <= req_pred_bg;
               mb_ff         <= req_mask_byte;
               tv_ff         <= req_trimap_value;
               last_img_ff   <= req_last_in_image || req_last_in_batch;
               last_batch_ff <= req_last_in_batch;
            end
         end
         ST_PREP: begin
            norm_ff <= norm_calc;
            m_ff    <= mask_prod[RECIP_SHIFT +: MASK_W];
            side_ff <= 1'b0;
         end
         ST_DIFF: begin
            mag_fg_ff <= {abs_fg, {WIDE_SHIFT{1'b0}}};
            mag_bg_ff <= {abs_bg, {WIDE_SHIFT{1'b0}}};
            neg_fg_ff <= d_fg[DIFF_W-1];
            neg_bg_ff <= d_bg[DIFF_W-1];
         end
         ST_SQ: begin
            s_ff <= UNIT_W'(sq) + (UNIT_W'(cfg.epsilon_square) << 24);
         end
         ST_SQRT_WAIT: begin
            if (unit_rsp.done) begin
               root_ff <= unit_rsp.result[ROOT_W-1:0];
               if (!side_ff) root_fg_ff <= unit_rsp.result[ROOT_W-1:0];
            end
         end
         ST_DEN: begin
            den_ff <= root_ff * norm_ff;
            // zero root: no division, gradient is zero
            if (root_ff == '0) begin
               if (side_ff) gbg_ff <= '0;
               else         gfg_ff <= '0;
            end
         end
         ST_DIV_WAIT: begin
            if (unit_rsp.done) begin
               if (side_ff) gbg_ff <= neg_bg_ff ? -quot : quot;
               else         gfg_ff <= neg_fg_ff ? -quot : quot;
            end
         end
         ST_SIDE_END: begin
            side_ff <= 1'b1;
         end
         ST_ACC: begin
            rsp_grad_fg_ff     <= kept ? $signed(gfg_ff) : '0;
            rsp_grad_bg_ff     <= kept ? $signed(gbg_ff) : '0;
            rsp_image_loss_ff  <= '0;
            rsp_image_empty_ff <= 1'b0;
            rsp_image_done_ff  <= last_img_ff;
            rsp_batch_loss_ff  <= '0;
            rsp_batch_done_ff  <= last_batch_ff;
         end
         ST_LOSS_GO: begin
            loss_ff  <= '0;
            empty_ff <= (kept_ff == '0);
         end
         ST_LOSS_WAIT: begin
            if (unit_rsp.done) begin
               loss_ff <= (unit_rsp.result > UNIT_W'(16'hFFFF))
                          ? 16'hFFFF : unit_rsp.result[LOSS_W-1:0];
            end
         end
         ST_CLOSE: begin
            rsp_image_loss_ff  <= loss_ff;
            rsp_image_empty_ff <= empty_ff;
            if (last_batch_ff) begin
               rsp_batch_loss_ff <= batch_add[BATCH_W] ? BATCH_MAX : batch_add[BATCH_W-1:0];
            end
         end
         default: begin
            side_ff <= side_ff;
         end
      endcase
   end

   assign rsp_grad_fg     = rsp_grad_fg_ff;
   assign rsp_grad_bg     = rsp_grad_bg_ff;
   assign rsp_image_loss  = rsp_image_loss_ff;
   assign rsp_image_done  = rsp_image_done_ff;
   assign rsp_image_empty = rsp_image_empty_ff;
   assign rsp_batch_loss  = rsp_batch_loss_ff;
   assign rsp_batch_done  = rsp_batch_done_ff;

endmodule

// ===== hw/rtl/alpha_matte_charbonnier_loss_unit.sv =====
// Top level of the alpha matte Charbonnier loss unit.
// Instantiates amcl_csr, amcl_iter_unit and amcl_seq; depends on amcl_pkg.
//
// One pixel transaction at a time. With no result stall, the time from one accept to the
// next, longer on the last pixel of an image, is set by the single shared root/divide unit,
// which retires one result bit per cycle (a square root and a gradient division, twice each
// per pixel, plus a loss division at image end), and by the sequencing states. A side whose
// root is zero skips its division; an empty image skips the loss division. req_ready is high
// only while the block is idle; the result stays on rsp_* until taken.
// Write configuration only while idle.
module alpha_matte_charbonnier_loss_unit #(
   parameter int unsigned MAX_IMAGE_PIXELS = amcl_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [15:0]          req_pred_fg,
   input  logic signed [15:0]          req_pred_bg,
   input  logic [7:0]                  req_mask_byte,
   input  logic [7:0]                  req_trimap_value,
   input  logic                        req_last_in_image,
   input  logic                        req_last_in_batch,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [31:0]          rsp_grad_fg,
   output logic signed [31:0]          rsp_grad_bg,
   output logic [15:0]                 rsp_image_loss,
   output logic                        rsp_image_done,
   output logic                        rsp_image_empty,
   output logic [39:0]                 rsp_batch_loss,
   output logic                        rsp_batch_done,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [amcl_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import amcl_pkg::*;

   cfg_type      cfg;
   unit_req_type unit_req;
   unit_rsp_type unit_rsp;

   amcl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   amcl_iter_unit u_unit (
      .clock (clock),
      .reset (reset),
      .req   (unit_req),
      .rsp   (unit_rsp)
   );

   amcl_seq #(
      .MAX_IMAGE_PIXELS (MAX_IMAGE_PIXELS)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pred_fg       (req_pred_fg),
      .req_pred_bg       (req_pred_bg),
      .req_mask_byte     (req_mask_byte),
      .req_trimap_value  (req_trimap_value),
      .req_last_in_image (req_last_in_image),
      .req_last_in_batch (req_last_in_batch),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_grad_fg       (rsp_grad_fg),
      .rsp_grad_bg       (rsp_grad_bg),
      .rsp_image_loss    (rsp_image_loss),
      .rsp_image_done    (rsp_image_done),
      .rsp_image_empty   (rsp_image_empty),
      .rsp_batch_loss    (rsp_batch_loss),
      .rsp_batch_done    (rsp_batch_done),
      .unit_req          (unit_req),
      .unit_rsp          (unit_rsp)
   );

endmodule

// ===== hw/rtl/amcl_checker.sv =====
// Port-level checks for the loss unit, bound to the top level.
// Depends on alpha_matte_charbonnier_loss_unit.
module amcl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_grad_fg,
   input logic [15:0] rsp_image_loss,
   input logic        rsp_image_done,
   input logic        rsp_image_empty,
   input logic        rsp_batch_done
);

   // one transaction in flight: no accept while a result is pending
   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("req_ready high while result pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("accepted while busy");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_grad_fg)))
      else $error("stalled result changed");

   a_loss_only_at_image_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_image_done) |-> (rsp_image_loss == 16'd0 && !rsp_image_empty))
      else $error("image fields set without image end");

   a_batch_closes_image: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_batch_done) |-> rsp_image_done)
      else $error("batch end without image end");

endmodule

bind alpha_matte_charbonnier_loss_unit amcl_checker u_amcl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_grad_fg     (rsp_grad_fg),
   .rsp_image_loss  (rsp_image_loss),
   .rsp_image_done  (rsp_image_done),
   .rsp_image_empty (rsp_image_empty),
   .rsp_batch_done  (rsp_batch_done)
);
